[hw/rtl/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared widths, parameter codes, phase type and attribute types for the
// select-graphic-rendition attribute decoder.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int PARAM_W = 16;
   localparam int COLOR_W = 5;
   localparam int STYLE_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes, taken from paddr[2]
   localparam logic CSR_DEFAULT_FG = 1'b0;
   localparam logic CSR_DEFAULT_BG = 1'b1;

   localparam logic [COLOR_W-1:0] RESET_DEFAULT_FG = 5'd16;
   localparam logic [COLOR_W-1:0] RESET_DEFAULT_BG = 5'd17;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 5'd7;

   // style bit positions
   localparam int BIT_BOLD      = 0;
   localparam int BIT_DIM       = 1;
   localparam int BIT_ITALIC    = 2;
   localparam int BIT_UNDERLINE = 3;
   localparam int BIT_INVERSE   = 4;
   localparam int BIT_CONCEAL   = 5;
   localparam int BIT_STRIKE    = 6;

   // parameter codes
   localparam logic [PARAM_W-1:0] CODE_RESET        = 16'd0;
   localparam logic [PARAM_W-1:0] CODE_BOLD         = 16'd1;
   localparam logic [PARAM_W-1:0] CODE_DIM          = 16'd2;
   localparam logic [PARAM_W-1:0] CODE_ITALIC       = 16'd3;
   localparam logic [PARAM_W-1:0] CODE_UNDERLINE    = 16'd4;
   localparam logic [PARAM_W-1:0] CODE_INVERSE      = 16'd7;
   localparam logic [PARAM_W-1:0] CODE_CONCEAL      = 16'd8;
   localparam logic [PARAM_W-1:0] CODE_STRIKE       = 16'd9;
   localparam logic [PARAM_W-1:0] CODE_DBL_UNDERL   = 16'd21;
   localparam logic [PARAM_W-1:0] CODE_NORMAL       = 16'd22;
   localparam logic [PARAM_W-1:0] CODE_NO_ITALIC    = 16'd23;
   localparam logic [PARAM_W-1:0] CODE_NO_UNDERLINE = 16'd24;
   localparam logic [PARAM_W-1:0] CODE_NO_INVERSE   = 16'd27;
   localparam logic [PARAM_W-1:0] CODE_NO_CONCEAL   = 16'd28;
   localparam logic [PARAM_W-1:0] CODE_NO_STRIKE    = 16'd29;
   localparam logic [PARAM_W-1:0] CODE_FG_LO        = 16'd30;
   localparam logic [PARAM_W-1:0] CODE_FG_HI        = 16'd37;
   localparam logic [PARAM_W-1:0] CODE_FG_EXT       = 16'd38;
   localparam logic [PARAM_W-1:0] CODE_FG_DEFAULT   = 16'd39;
   localparam logic [PARAM_W-1:0] CODE_BG_LO        = 16'd40;
   localparam logic [PARAM_W-1:0] CODE_BG_HI        = 16'd47;
   localparam logic [PARAM_W-1:0] CODE_BG_EXT       = 16'd48;
   localparam logic [PARAM_W-1:0] CODE_BG_DEFAULT   = 16'd49;
   localparam logic [PARAM_W-1:0] CODE_FG_BRIGHT_LO = 16'd90;
   localparam logic [PARAM_W-1:0] CODE_FG_BRIGHT_HI = 16'd97;
   localparam logic [PARAM_W-1:0] CODE_BG_BRIGHT_LO = 16'd100;
   localparam logic [PARAM_W-1:0] CODE_BG_BRIGHT_HI = 16'd107;
   localparam logic [PARAM_W-1:0] MODE_RGB          = 16'd2;
   localparam logic [PARAM_W-1:0] MODE_INDEXED      = 16'd5;
   localparam logic [PARAM_W-1:0] INDEX_MAX         = 16'd255;
   localparam logic [PARAM_W-1:0] INDEX_PALETTE_END = 16'd16;
   // bright codes map to palette 8-15
   localparam logic [PARAM_W-1:0] FG_BRIGHT_BIAS    = 16'd82;
   localparam logic [PARAM_W-1:0] BG_BRIGHT_BIAS    = 16'd92;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_WANT_MODE = 3'd1,
      PH_WANT_VAL  = 3'd2,
      PH_RGB_G     = 3'd3,
      PH_RGB_B     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic [STYLE_W-1:0] style;
   } attr_type;

   typedef struct packed {
      attr_type attr;
      logic     pending;
   } result_type;

endpackage

[hw/rtl/sgr_attribute_decoder.sv]
// ----------------------------------------------------------------------------
// sgr_attribute_decoder
// Decodes SGR parameters, one per item, into the current colours and style.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered in the output register, or in the skid entry while rsp_ stalls.
// Throughput: one item per cycle while req_stall is low; the attribute update is a
// single compare and select pass on the state registers.
// A two-entry output buffer lets input run on for one item while rsp_ stalls.
// Reset: synchronous; attributes return to default colours and no style,
// default colour registers to 16 and 17, no extended form pending.
module sgr_attribute_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sgr_pkg::PARAM_W-1:0]         req_param_value,
   input  logic                                req_last_param,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sgr_pkg::COLOR_W-1:0]         rsp_fg_color,
   output logic [sgr_pkg::COLOR_W-1:0]         rsp_bg_color,
   output logic [sgr_pkg::STYLE_W-1:0]         rsp_style_bits,
   output logic                                rsp_extended_pending,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sgr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sgr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import sgr_pkg::*;

   logic [COLOR_W-1:0] dflt_fg_ff, dflt_fg_in;
   logic [COLOR_W-1:0] dflt_bg_ff, dflt_bg_in;
   attr_type           attr_ff, attr_in;
   phase_type          phase_ff, phase_in;
   logic               target_bg_ff, target_bg_in;
   logic               mode_indexed_ff, mode_indexed_in;
   logic               mode_rgb_ff, mode_rgb_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   result_type         skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic       csr_write;
   logic       req_take;
   logic       rsp_take;
   logic       is_ext_code;
   result_type result;

   function automatic attr_type apply_plain(
      input attr_type           a,
      input logic [PARAM_W-1:0] p,
      input logic [COLOR_W-1:0] dfg,
      input logic [COLOR_W-1:0] dbg
   );
      attr_type r;
      r = a;
      case (p)
         CODE_RESET: begin
            r.style = '0;
            r.fg    = dfg;
            r.bg    = dbg;
         end
         CODE_BOLD: r.style[BIT_BOLD] = 1'b1;
         CODE_DIM: begin
            r.style[BIT_DIM]  = 1'b1;
            r.style[BIT_BOLD] = 1'b0;
         end
         CODE_ITALIC:       r.style[BIT_ITALIC] = 1'b1;
         CODE_UNDERLINE,
         CODE_DBL_UNDERL:   r.style[BIT_UNDERLINE] = 1'b1;
         CODE_INVERSE:      r.style[BIT_INVERSE] = 1'b1;
         CODE_CONCEAL:      r.style[BIT_CONCEAL] = 1'b1;
         CODE_STRIKE:       r.style[BIT_STRIKE] = 1'b1;
         CODE_NORMAL: begin
            r.style[BIT_BOLD] = 1'b0;
            r.style[BIT_DIM]  = 1'b0;
         end
         CODE_NO_ITALIC:    r.style[BIT_ITALIC] = 1'b0;
         CODE_NO_UNDERLINE: r.style[BIT_UNDERLINE] = 1'b0;
         CODE_NO_INVERSE:   r.style[BIT_INVERSE] = 1'b0;
         CODE_NO_CONCEAL:   r.style[BIT_CONCEAL] = 1'b0;
         CODE_NO_STRIKE:    r.style[BIT_STRIKE] = 1'b0;
         CODE_FG_DEFAULT:   r.fg = dfg;
         CODE_BG_DEFAULT:   r.bg = dbg;
         default: begin
            if (p >= CODE_FG_LO && p <= CODE_FG_HI) begin
               r.fg = COLOR_W'(p - CODE_FG_LO);
            end else if (p >= CODE_BG_LO && p <= CODE_BG_HI) begin
               r.bg = COLOR_W'(p - CODE_BG_LO);
            end else if (p >= CODE_FG_BRIGHT_LO && p <= CODE_FG_BRIGHT_HI) begin
               r.fg = COLOR_W'(p - FG_BRIGHT_BIAS);
            end else if (p >= CODE_BG_BRIGHT_LO && p <= CODE_BG_BRIGHT_HI) begin
               r.bg = COLOR_W'(p - BG_BRIGHT_BIAS);
            end
         end
      endcase
      return r;
   endfunction

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dflt_fg_in = dflt_fg_ff;
      dflt_bg_in = dflt_bg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_DEFAULT_FG: dflt_fg_in = csr_pwdata[COLOR_W-1:0];
            CSR_DEFAULT_BG: dflt_bg_in = csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         CSR_DEFAULT_FG: csr_prdata = CSR_DATA_W'(dflt_fg_ff);
         CSR_DEFAULT_BG: csr_prdata = CSR_DATA_W'(dflt_bg_ff);
         default: ;
      endcase
   end

   // handshake
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign is_ext_code = (req_param_value == CODE_FG_EXT) || (req_param_value == CODE_BG_EXT);

   // attribute update for one item
   always_comb begin
      attr_in         = attr_ff;
      phase_in        = PH_IDLE;
      target_bg_in    = target_bg_ff;
      mode_indexed_in = mode_indexed_ff;
      mode_rgb_in     = mode_rgb_ff;
      unique case (phase_ff)
         PH_WANT_MODE: begin
            if (req_last_param) begin
               // form cut short: the parameter counts as an ordinary code
               if (!is_ext_code) begin
                  attr_in = apply_plain(attr_ff, req_param_value, dflt_fg_ff, dflt_bg_ff);
               end
            end else begin
               mode_indexed_in = (req_param_value == MODE_INDEXED);
               mode_rgb_in     = (req_param_value == MODE_RGB);
               phase_in        = PH_WANT_VAL;
            end
         end
         PH_WANT_VAL: begin
            if (mode_indexed_ff && req_param_value <= INDEX_MAX) begin
               if (target_bg_ff) begin
                  attr_in.bg = (req_param_value < INDEX_PALETTE_END) ?
                               req_param_value[COLOR_W-1:0] : COLOR_WHITE;
               end else begin
                  attr_in.fg = (req_param_value < INDEX_PALETTE_END) ?
                               req_param_value[COLOR_W-1:0] : COLOR_WHITE;
               end
            end
            phase_in = (mode_rgb_ff && !req_last_param) ? PH_RGB_G : PH_IDLE;
         end
         PH_RGB_G: begin
            if (req_last_param) begin
               if (!is_ext_code) begin
                  attr_in = apply_plain(attr_ff, req_param_value, dflt_fg_ff, dflt_bg_ff);
               end
            end else begin
               phase_in = PH_RGB_B;
            end
         end
         PH_RGB_B: phase_in = PH_IDLE;
         default: begin
            if (is_ext_code) begin
               if (!req_last_param) begin
                  target_bg_in = (req_param_value == CODE_BG_EXT);
                  phase_in     = PH_WANT_MODE;
               end
            end else begin
               attr_in = apply_plain(attr_ff, req_param_value, dflt_fg_ff, dflt_bg_ff);
            end
         end
      endcase
      result.attr    = attr_in;
      result.pending = (phase_in != PH_IDLE);
   end

   // output register with one skid entry behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_fg_ff      <= RESET_DEFAULT_FG;
         dflt_bg_ff      <= RESET_DEFAULT_BG;
         attr_ff.fg      <= RESET_DEFAULT_FG;
         attr_ff.bg      <= RESET_DEFAULT_BG;
         attr_ff.style   <= '0;
         phase_ff        <= PH_IDLE;
         target_bg_ff    <= 1'b0;
         mode_indexed_ff <= 1'b0;
         mode_rgb_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         dflt_fg_ff    <= dflt_fg_in;
         dflt_bg_ff    <= dflt_bg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_take) begin
            attr_ff         <= attr_in;
            phase_ff        <= phase_in;
            target_bg_ff    <= target_bg_in;
            mode_indexed_ff <= mode_indexed_in;
            mode_rgb_ff     <= mode_rgb_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_fg_color         = out_ff.attr.fg;
   assign rsp_bg_color         = out_ff.attr.bg;
   assign rsp_style_bits       = out_ff.attr.style;
   assign rsp_extended_pending = out_ff.pending;

endmodule

[hw/rtl/sgr_checker.sv]
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level checks on the SGR attribute decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
module sgr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_last_param,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [sgr_pkg::COLOR_W-1:0]    rsp_fg_color,
   input logic [sgr_pkg::COLOR_W-1:0]    rsp_bg_color,
   input logic [sgr_pkg::STYLE_W-1:0]    rsp_style_bits,
   input logic                           rsp_extended_pending
);
   import sgr_pkg::*;

   // stalled result keeps its place
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_fg_color, rsp_bg_color, rsp_style_bits,
                                          rsp_extended_pending}))
      else $error("stalled result changed");

   // an item into an empty output shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> rsp_valid)
      else $error("accepted item gave no result");

   // the final parameter always closes any extended form
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_param && !rsp_valid |=> !rsp_extended_pending)
      else $error("extended form left open after last parameter");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind sgr_attribute_decoder sgr_checker u_sgr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_last_param       (req_last_param),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_fg_color         (rsp_fg_color),
   .rsp_bg_color         (rsp_bg_color),
   .rsp_style_bits       (rsp_style_bits),
   .rsp_extended_pending (rsp_extended_pending)
);
